// ----- hw/rtl/boxavg_pkg.sv -----
// ----------------------------------------------------------------------------
// Boxcar average package
// Shared constants, the sequencer state type and ring-buffer address helper
// for the edge-clamped boxcar averaging block.
// ----------------------------------------------------------------------------
package boxavg_pkg;

	localparam int MAX_HALF_WIDTH = 31;
	localparam int SAMPLE_BITS    = 16;
	localparam int HW_BITS        = 5;

	localparam int STORE_DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int PTR_BITS    = $clog2(STORE_DEPTH);
	localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + $clog2(STORE_DEPTH);

	localparam logic [PTR_BITS:0] DEPTH_EXT = (PTR_BITS + 1)'(STORE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVICT,
		S_CHECK,
		S_DIV,
		S_OUT,
		S_FLUSH_INIT,
		S_FLUSH_CHK,
		S_FLUSH_SUB
	} state_t;

	// Slot that holds the sample 'back' positions before the write pointer.
	function automatic logic [PTR_BITS-1:0] slot_back(input logic [PTR_BITS-1:0] ptr,
			input logic [CNT_BITS-1:0] back);
		logic [PTR_BITS:0] t;
		t = {1'b0, ptr} + DEPTH_EXT - (PTR_BITS + 1)'(back);
		if (t >= DEPTH_EXT) begin
			t = t - DEPTH_EXT;
		end
		return t[PTR_BITS-1:0];
	endfunction

endpackage

// ----- hw/rtl/boxavg_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module boxavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/boxavg_div.sv -----
// ----------------------------------------------------------------------------
// Boxcar average divider
// Radix-2 restoring divider, one quotient bit a cycle, signed dividend,
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module boxavg_div
	import boxavg_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SUM_BITS-1:0]    dividend,
	input  logic        [CNT_BITS-1:0]    divisor,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] quotient
);

	localparam int STEP_BITS = $clog2(SUM_BITS);

	logic                   busy_q;
	logic                   done_q;
	logic [STEP_BITS-1:0]   step_q;
	logic                   neg_q;
	logic [SUM_BITS-1:0]    mag_q;
	logic [CNT_BITS-1:0]    rem_q;
	logic [CNT_BITS-1:0]    dvs_q;

	logic [CNT_BITS:0]      trial;
	logic [CNT_BITS:0]      diff;
	logic                   ge;
	logic [SAMPLE_BITS-1:0] q_mag;

	assign trial = {rem_q, mag_q[SUM_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};
	assign q_mag = mag_q[SAMPLE_BITS-1:0];

	assign done     = done_q;
	assign quotient = $signed(neg_q ? (~q_mag + 1'b1) : q_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_BITS'(SUM_BITS - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The dividend register shifts out its bits and takes in the quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_BITS-1];
			mag_q <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_BITS-2:0], ge};
			rem_q <= ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
		end
	end

endmodule

// ----- hw/rtl/boxavg_average_edge_clamped_top_placeholder.sv -----
// ----------------------------------------------------------------------------
// Boxcar average sequencer helper
// Works out the window width and flush decisions from the stream counters.
// ----------------------------------------------------------------------------
module boxavg_ctrl
	import boxavg_pkg::*;
(
	input  logic [HW_BITS-1:0]  hw,
	input  logic [CNT_BITS-1:0] seen,
	input  logic [CNT_BITS-1:0] pend,
	input  logic [CNT_BITS-1:0] fcnt,
	output logic [HW_BITS-1:0]  eff_hw,
	output logic [CNT_BITS-1:0] win,
	output logic                evict,
	output logic                hit_out,
	output logic                shrink
);

	logic [CNT_BITS:0] pend_plus;
	logic [CNT_BITS:0] need;

	always_comb begin
		eff_hw = hw;
		if (hw == '0) begin
			eff_hw = HW_BITS'(1);
		end else if (32'(hw) > MAX_HALF_WIDTH) begin
			eff_hw = HW_BITS'(MAX_HALF_WIDTH);
		end
		win       = CNT_BITS'({eff_hw, 1'b1});
		evict     = seen >= win;
		hit_out   = pend > CNT_BITS'(eff_hw);
		pend_plus = (CNT_BITS + 1)'(pend) + (CNT_BITS + 1)'(eff_hw);
		need      = (pend_plus > (CNT_BITS + 1)'(seen)) ? (CNT_BITS + 1)'(seen) : pend_plus;
		shrink    = (CNT_BITS + 1)'(fcnt) > need;
	end

endmodule

// ----- hw/rtl/boxcar_average_edge_clamped.sv -----
// ----------------------------------------------------------------------------
// Edge-clamped boxcar moving average
// Each request passes through the sequencer states EVICT and CHECK; one that
//   yields a result then waits in DIV for the divider and is shown in OUT.
// A new request is taken only in IDLE, once the last one is through; a
//   last-flagged request then flushes the remaining results through FLUSH_INIT,
//   FLUSH_CHK and FLUSH_SUB. Stalls on the result side hold the sequencer in OUT.
// The divider works out one quotient bit a cycle while it is busy.
// Reset: clears the stream counters, sets half_width to 1; the store is not
//   cleared, as every entry is written before it is read within a vector.
// ----------------------------------------------------------------------------
module boxcar_average_edge_clamped
	import boxavg_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic        [HW_BITS-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_in_vector,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          last_of_vector
);

	// Sequencer state.
	state_t state_q, state_d;

	// Stream state: ring-buffer pointer, running sum of the samples held, how
	// many samples are held and how many have not yet produced a result.
	logic        [HW_BITS-1:0]     hw_q;
	logic        [PTR_BITS-1:0]    wp_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic        [CNT_BITS-1:0]    seen_q;
	logic        [CNT_BITS-1:0]    pend_q;
	logic                          flush_q;

	// The request being worked on.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          last_q;

	// Flush working copies: the sum and count of the shrinking window.
	logic signed [SUM_BITS-1:0]    fsum_q;
	logic        [CNT_BITS-1:0]    fcnt_q;

	// Result register.
	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic                          olast_q;

	logic        [HW_BITS-1:0]     eff_hw;
	logic        [CNT_BITS-1:0]    win;
	logic                          evict;
	logic                          hit_out;
	logic                          shrink;

	logic        [PTR_BITS-1:0]    raddr;
	logic        [SAMPLE_BITS-1:0] rdata;
	logic signed [SUM_BITS-1:0]    old_ext;
	logic signed [SUM_BITS-1:0]    new_ext;
	logic                          ram_we;

	logic                          div_start;
	logic signed [SUM_BITS-1:0]    div_dividend;
	logic        [CNT_BITS-1:0]    div_divisor;
	logic                          div_done;
	logic signed [SAMPLE_BITS-1:0] div_quotient;

	boxavg_ctrl u_ctrl (
		.hw      (hw_q),
		.seen    (seen_q),
		.pend    (pend_q),
		.fcnt    (fcnt_q),
		.eff_hw  (eff_hw),
		.win     (win),
		.evict   (evict),
		.hit_out (hit_out),
		.shrink  (shrink)
	);

	// During the flush the oldest sample of the shrinking window is read;
	// otherwise it is the sample that falls out of a full window. The read is
	// issued on acceptance, before the new sample may overwrite that slot.
	assign raddr  = (state_q == S_FLUSH_CHK) ? slot_back(wp_q, fcnt_q) : slot_back(wp_q, win);
	assign ram_we = (state_q == S_EVICT);

	boxavg_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (x_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign old_ext = SUM_BITS'($signed(rdata));
	assign new_ext = SUM_BITS'(x_q);

	boxavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = (state_q == S_OUT);
	assign average        = avg_q;
	assign last_of_vector = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider launch.
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = sum_q;
		div_divisor  = seen_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EVICT;
				end
			end
			S_EVICT: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				// Enough samples past the centre: the centred result is due.
				if (hit_out) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else if (last_q) begin
					state_d = S_FLUSH_INIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					if (flush_q) begin
						state_d = S_FLUSH_CHK;
					end else if (last_q) begin
						state_d = S_FLUSH_INIT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FLUSH_INIT: begin
				state_d = S_FLUSH_CHK;
			end
			S_FLUSH_CHK: begin
				// Near the end of the vector the window loses its oldest
				// samples one by one before each remaining result.
				if (pend_q == '0) begin
					state_d = S_IDLE;
				end else if (shrink) begin
					state_d = S_FLUSH_SUB;
				end else begin
					div_start    = 1'b1;
					div_dividend = fsum_q;
					div_divisor  = fcnt_q;
					state_d      = S_DIV;
				end
			end
			S_FLUSH_SUB: begin
				state_d = S_FLUSH_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Stream state, cleared by reset, by the end of a flush and by a write of
	// the half width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q    <= HW_BITS'(1);
			wp_q    <= '0;
			sum_q   <= '0;
			seen_q  <= '0;
			pend_q  <= '0;
			flush_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_in_vector;
					end
				end
				S_EVICT: begin
					// A full window drops its oldest sample as the new one enters.
					sum_q  <= sum_q - (evict ? old_ext : '0) + new_ext;
					seen_q <= evict ? win : seen_q + 1'b1;
					pend_q <= pend_q + 1'b1;
					wp_q   <= (wp_q == PTR_BITS'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				end
				S_CHECK: begin
					if (hit_out) begin
						pend_q <= pend_q - 1'b1;
					end
				end
				S_FLUSH_INIT: begin
					flush_q <= 1'b1;
				end
				S_FLUSH_CHK: begin
					if (pend_q == '0) begin
						wp_q    <= '0;
						sum_q   <= '0;
						seen_q  <= '0;
						flush_q <= 1'b0;
					end else if (!shrink) begin
						pend_q <= pend_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (cfg_wr_en) begin
				hw_q   <= cfg_wr_data;
				wp_q   <= '0;
				sum_q  <= '0;
				seen_q <= '0;
				pend_q <= '0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					x_q <= sample;
				end
			end
			S_CHECK: begin
				if (hit_out) begin
					olast_q <= 1'b0;
				end
			end
			S_DIV: begin
				if (div_done) begin
					avg_q <= div_quotient;
				end
			end
			S_FLUSH_INIT: begin
				fsum_q <= sum_q;
				fcnt_q <= seen_q;
			end
			S_FLUSH_CHK: begin
				if (pend_q != '0 && !shrink) begin
					olast_q <= (pend_q == CNT_BITS'(1));
				end
			end
			S_FLUSH_SUB: begin
				fsum_q <= fsum_q - old_ext;
				fcnt_q <= fcnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
